/* sv/mnpa_pkg.sv */
// Shared types and constants of the mono note priority allocator.
// Used by mnpa_ctrl, mnpa_dpath and mono_note_priority_allocator; no dependencies.
package mnpa_pkg;

  localparam int unsigned HELD_DEPTH_DEF = 16;
  localparam int unsigned UNISON_COPIES  = 8;
  localparam int unsigned COPY_W         = $clog2(UNISON_COPIES);

  localparam logic [2:0] MODE_POLY      = 3'd0;
  localparam logic [2:0] MODE_UNISON    = 3'd1;
  localparam logic [2:0] MODE_SOLO_LAST = 3'd2;
  localparam logic [2:0] MODE_SOLO_LOW  = 3'd3;
  localparam logic [2:0] MODE_SOLO_HIGH = 3'd4;

  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;

  localparam logic [7:0] STATUS_OFF_CH1 = 8'h80;
  localparam logic [7:0] STATUS_ON_CH1  = 8'h90;

  typedef enum logic [1:0] {
    EK_PASS = 2'd0,
    EK_OFF  = 2'd1,
    EK_ON   = 2'd2
  } emit_e;

  typedef enum logic [2:0] {
    IX_HOLD = 3'd0,
    IX_ZERO = 3'd1,
    IX_ONE  = 3'd2,
    IX_INC  = 3'd3,
    IX_TOP  = 3'd4
  } idx_op_e;

  typedef struct packed {
    logic    load;
    logic    emit;
    emit_e   emit_kind;
    logic    emit_last;
    idx_op_e idx_op;
    logic    shift_wr;
    logic    push;
    logic    cnt_dec;
    logic    win_load;
    logic    scan_cmp;
    logic    copies_load;
    logic    copies_dec;
    logic    sv_clear;
    logic    sound_set;
  } mnpa_cmd_t;

  typedef struct packed {
    logic is_on;
    logic is_off;
    logic solo;
    logic idx_at_end;
    logic full;
    logic empty;
    logic match;
    logic sv;
    logic win_ne_sn;
    logic d1_eq_sn;
    logic copies_zero;
  } mnpa_stat_t;

endpackage

/* sv/mnpa_ctrl.sv */
// Sequencer of the mono note priority allocator.
// Depends on mnpa_pkg; drives mnpa_dpath through command and status structs.
module mnpa_ctrl import mnpa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  mnpa_stat_t stat_i,
  output mnpa_cmd_t  cmd_o
);

  typedef enum logic [14:0] {
    ST_IDLE     = 15'b000000000000001,
    ST_DISPATCH = 15'b000000000000010,
    ST_PASS     = 15'b000000000000100,
    ST_SH_RD    = 15'b000000000001000,
    ST_SH_WR    = 15'b000000000010000,
    ST_FIND_RD  = 15'b000000000100000,
    ST_FIND_CMP = 15'b000000001000000,
    ST_PUSH     = 15'b000000010000000,
    ST_POST_OFF = 15'b000000100000000,
    ST_TOP_RD   = 15'b000001000000000,
    ST_TOP_LD   = 15'b000010000000000,
    ST_SCAN_RD  = 15'b000100000000000,
    ST_SCAN_CMP = 15'b001000000000000,
    ST_EMIT_OFF = 15'b010000000000000,
    ST_EMIT_ON  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!stat_i.solo || (!stat_i.is_on && !stat_i.is_off)) begin
          cmd_o.copies_load = 1'b1;
          state_d           = ST_PASS;
        end else if (stat_i.is_on) begin
          if (stat_i.full) begin
            cmd_o.idx_op = IX_ONE;
            state_d      = ST_SH_RD;
          end else begin
            state_d = ST_PUSH;
          end
        end else begin
          cmd_o.idx_op = IX_ZERO;
          state_d      = ST_FIND_RD;
        end
      end
      ST_PASS: begin
        cmd_o.emit       = 1'b1;
        cmd_o.emit_kind  = EK_PASS;
        cmd_o.emit_last  = stat_i.copies_zero;
        cmd_o.copies_dec = 1'b1;
        if (stat_i.copies_zero) begin
          state_d = ST_IDLE;
        end
      end
      ST_FIND_RD: begin
        if (stat_i.idx_at_end) begin
          state_d = ST_POST_OFF;
        end else begin
          state_d = ST_FIND_CMP;
        end
      end
      ST_FIND_CMP: begin
        cmd_o.idx_op = IX_INC;
        if (stat_i.match) begin
          state_d = ST_SH_RD;
        end else begin
          state_d = ST_FIND_RD;
        end
      end
      ST_SH_RD: begin
        if (stat_i.idx_at_end) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = stat_i.is_on ? ST_PUSH : ST_POST_OFF;
        end else begin
          state_d = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        cmd_o.shift_wr = 1'b1;
        cmd_o.idx_op   = IX_INC;
        state_d        = ST_SH_RD;
      end
      ST_PUSH: begin
        cmd_o.push   = 1'b1;
        cmd_o.idx_op = IX_ZERO;
        state_d      = ST_SCAN_RD;
      end
      ST_POST_OFF: begin
        if (stat_i.empty) begin
          // stack drained: release the voice if one sounds
          cmd_o.emit      = stat_i.sv;
          cmd_o.emit_kind = EK_OFF;
          cmd_o.emit_last = 1'b1;
          cmd_o.sv_clear  = 1'b1;
          state_d         = ST_IDLE;
        end else if (stat_i.sv && stat_i.d1_eq_sn) begin
          cmd_o.idx_op = IX_TOP;
          state_d      = ST_TOP_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_TOP_RD: begin
        state_d = ST_TOP_LD;
      end
      ST_TOP_LD: begin
        cmd_o.win_load = 1'b1;
        cmd_o.idx_op   = IX_ZERO;
        state_d        = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (stat_i.idx_at_end) begin
          if (stat_i.is_on && !(stat_i.sv && stat_i.win_ne_sn)) begin
            state_d = ST_EMIT_ON;
          end else begin
            state_d = ST_EMIT_OFF;
          end
        end else begin
          state_d = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        cmd_o.idx_op   = IX_INC;
        state_d        = ST_SCAN_RD;
      end
      ST_EMIT_OFF: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_kind = EK_OFF;
        state_d         = ST_EMIT_ON;
      end
      ST_EMIT_ON: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_kind = EK_ON;
        cmd_o.emit_last = 1'b1;
        cmd_o.sound_set = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/mnpa_dpath.sv */
// Datapath of the mono note priority allocator: held-note stack memory,
// index and count registers, winner and sounding-note registers, result register.
// Depends on mnpa_pkg; steered by mnpa_ctrl.
module mnpa_dpath import mnpa_pkg::*; #(
  parameter int unsigned HELD_DEPTH = HELD_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_data_i,
  input  logic [7:0] status_i,
  input  logic [6:0] data1_i,
  input  logic [6:0] data2_i,
  input  mnpa_cmd_t  cmd_i,
  output mnpa_stat_t stat_o,
  output logic       out_valid_o,
  output logic [7:0] out_status_o,
  output logic [6:0] out_data1_o,
  output logic [6:0] out_data2_o,
  output logic       last_o
);

  localparam int unsigned IW = $clog2(HELD_DEPTH);
  localparam int unsigned CW = $clog2(HELD_DEPTH + 1);

  logic [2:0]        mode_q;
  logic [7:0]        st_q;
  logic [6:0]        d1_q, d2_q;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     idx_m1;
  logic [6:0]        win_q, wvel_q;
  logic [6:0]        sn_q;
  logic              sv_q;
  logic [COPY_W-1:0] copies_q;
  logic [13:0]       mem_q [HELD_DEPTH];
  logic [13:0]       rdata_q;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [13:0]       mem_wdata;
  logic [6:0]        rnote, rvel;
  logic              better;
  logic              out_valid_q, last_q;
  logic [7:0]        out_status_q;
  logic [6:0]        out_data1_q, out_data2_q;

  assign rnote = rdata_q[13:7];
  assign rvel  = rdata_q[6:0];

  assign stat_o.is_on       = (st_q[7:4] == NIB_NOTE_ON) && (d2_q != '0);
  assign stat_o.is_off      = (st_q[7:4] == NIB_NOTE_OFF) ||
                              ((st_q[7:4] == NIB_NOTE_ON) && (d2_q == '0));
  assign stat_o.solo        = (mode_q >= MODE_SOLO_LAST);
  assign stat_o.idx_at_end  = (idx_q == count_q);
  assign stat_o.full        = (count_q == CW'(HELD_DEPTH));
  assign stat_o.empty       = (count_q == '0);
  assign stat_o.match       = (rnote == d1_q);
  assign stat_o.sv          = sv_q;
  assign stat_o.win_ne_sn   = (win_q != sn_q);
  assign stat_o.d1_eq_sn    = (d1_q == sn_q);
  assign stat_o.copies_zero = (copies_q == '0);

  // strict compare: a tie keeps the current winner
  assign better = ((mode_q == MODE_SOLO_LOW) && (rnote < win_q)) ||
                  ((mode_q == MODE_SOLO_HIGH) && (rnote > win_q));

  assign idx_m1    = idx_q - 1'b1;
  assign mem_we    = cmd_i.shift_wr || cmd_i.push;
  assign mem_waddr = cmd_i.shift_wr ? idx_m1[IW-1:0] : count_q[IW-1:0];
  assign mem_wdata = cmd_i.shift_wr ? rdata_q : {d1_q, d2_q};

  always_comb begin
    case (cmd_i.idx_op)
      IX_ZERO: idx_d = '0;
      IX_ONE:  idx_d = CW'(1);
      IX_INC:  idx_d = idx_q + 1'b1;
      IX_TOP:  idx_d = count_q - 1'b1;
      default: idx_d = idx_q;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - 1'b1;
    end
  end

  // stack memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[idx_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_POLY;
      count_q     <= '0;
      idx_q       <= '0;
      sn_q        <= '0;
      sv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= cmd_i.emit;
      if (cmd_i.sound_set) begin
        sn_q <= win_q;
        sv_q <= 1'b1;
      end else if (cmd_i.sv_clear) begin
        sv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      st_q <= status_i;
      d1_q <= data1_i;
      d2_q <= data2_i;
    end
    if (cmd_i.copies_load) begin
      copies_q <= ((mode_q == MODE_UNISON) && stat_o.is_on) ?
                  COPY_W'(UNISON_COPIES - 1) : '0;
    end else if (cmd_i.copies_dec) begin
      copies_q <= copies_q - 1'b1;
    end
    if (cmd_i.push) begin
      win_q  <= d1_q;
      wvel_q <= d2_q;
    end else if (cmd_i.win_load || (cmd_i.scan_cmp && better)) begin
      win_q  <= rnote;
      wvel_q <= rvel;
    end
    if (cmd_i.emit) begin
      last_q <= cmd_i.emit_last;
      case (cmd_i.emit_kind)
        EK_OFF: begin
          out_status_q <= STATUS_OFF_CH1;
          out_data1_q  <= sn_q;
          out_data2_q  <= '0;
        end
        EK_ON: begin
          out_status_q <= STATUS_ON_CH1;
          out_data1_q  <= win_q;
          out_data2_q  <= wvel_q;
        end
        default: begin
          out_status_q <= st_q;
          out_data1_q  <= d1_q;
          out_data2_q  <= d2_q;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_data1_o  = out_data1_q;
  assign out_data2_o  = out_data2_q;
  assign last_o       = last_q;

endmodule

/* sv/mono_note_priority_allocator.sv */
// Pass-through and unison results are issued one per cycle, as a run of results for the message.
// Solo note-on: a full stack first drops its oldest entry; the note is pushed, then the winner scan runs.
// Solo note-off: search, stack close-up, winner scan when the sounding note is released, up to two results.
// The stack memory has one read port, so search, shift and scan each visit one entry at a time.
// One message at a time; busy_o stays high until its last result is issued; the receiver cannot stall.
// Reset (rst_ni low) empties the stack, silences the voice and selects poly mode; no clearing pass.
module mono_note_priority_allocator import mnpa_pkg::*; #(
  parameter int unsigned HELD_DEPTH = HELD_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // message in: transfer on start_i while busy_o is low
  input  logic       start_i,
  output logic       busy_o,
  input  logic [7:0] status_i,
  input  logic [6:0] data1_i,
  input  logic [6:0] data2_i,
  // voice mode register, write only
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_data_i,
  // results: one transfer per cycle in which out_valid_o is high
  output logic       out_valid_o,
  output logic [7:0] out_status_o,
  output logic [6:0] out_data1_o,
  output logic [6:0] out_data2_o,
  output logic       last_o
);

  mnpa_cmd_t  cmd;
  mnpa_stat_t stat;

  // Sequencer: dispatch on mode and message type, walk the stack, issue results.
  mnpa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  // Datapath: held-note stack, winner tracking, sounding voice and result register.
  mnpa_dpath #(
    .HELD_DEPTH (HELD_DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .status_i     (status_i),
    .data1_i      (data1_i),
    .data2_i      (data2_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_status_o (out_status_o),
    .out_data1_o  (out_data1_o),
    .out_data2_o  (out_data2_o),
    .last_o       (last_o)
  );

endmodule
